[src/mbbn_pkg.sv]
// Package: constants and state codes for the mesh bounding box normalizer.
`timescale 1ns / 1ps
`default_nettype none
package mbbn_pkg;
  localparam int MaxVertices = 64;
  localparam int CoordWidth  = 16;
  localparam int AddrWidth   = 6;
  localparam int CountWidth  = 7;
  localparam int NormWidth   = 16;
  localparam int QuotWidth   = 15;
  localparam int ExtWidth    = CoordWidth;
  localparam int MagWidth    = CoordWidth + 1;
  localparam int RemWidth    = CoordWidth + 2;
  localparam int StepWidth   = 4;
  localparam logic [QuotWidth-1:0] QOne = QuotWidth'(16384);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExt  = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [2:0][CoordWidth-1:0] vec_t;
endpackage
`default_nettype wire

[src/mesh_bounding_box_normalize.sv]
// Top level: vertex store, bounding box tracking and normalizing emit pass.
//
// Usage: drive pos_x_i/pos_y_i/pos_z_i and last_vertex_i with start high; a
// transaction is accepted at a rising edge where start is high and busy is low.
// While loading, one vertex is accepted every cycle and busy stays low. Up to
// 64 vertices are stored; later ones are dropped and overflow_o is reported.
// The vertex marked last closes the mesh: busy rises, the extents are
// computed in state StExt, then every stored vertex is read from the vertex
// RAM, normalized by three 15-step restoring dividers and presented for
// one cycle with result_valid_o high. Each result passes through a RAM
// read, an operand load, 15 divider steps and an output state. The receiver
// cannot stall; results are not held. After the final result busy falls and
// the box, the vertex count and the read index return to their reset values.
// Reset is asynchronous, active low, and clears all control state; the RAM
// contents are not cleared and are only read after being written.
`timescale 1ns / 1ps
`default_nettype none
module mesh_bounding_box_normalize import mbbn_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CoordWidth-1:0] pos_x_i,
  input  wire logic [CoordWidth-1:0] pos_y_i,
  input  wire logic [CoordWidth-1:0] pos_z_i,
  input  wire logic                 last_vertex_i,
  output logic                      result_valid_o,
  output logic [NormWidth-1:0]      norm_x_o,
  output logic [NormWidth-1:0]      norm_y_o,
  output logic [NormWidth-1:0]      norm_z_o,
  output logic [AddrWidth-1:0]      vertex_index_o,
  output logic                      last_result_o,
  output logic                      degenerate_o,
  output logic                      overflow_o
);
  logic [3*CoordWidth-1:0] mem_q [MaxVertices];
  logic [3*CoordWidth-1:0] rd_q;

  logic [2:0] state_q, state_d;
  vec_t min_q, max_q, vin;
  logic [2:0][ExtWidth-1:0] ext_q;
  logic [ExtWidth-1:0] big_q, big_c;
  logic [2:0][ExtWidth-1:0] ext_c;
  logic [CountWidth-1:0] count_q;
  logic drop_q, degen_q;
  logic [AddrWidth-1:0] k_q;
  logic [StepWidth-1:0] step_q;
  logic [2:0][RemWidth-1:0] rem_q;
  logic [2:0][QuotWidth-1:0] quo_q;
  logic [2:0] neg_q;
  logic [QuotWidth-1:0] low_q;
  logic accept, store_en, last_k;
  logic [2:0][NormWidth-1:0] norm_c;

  assign vin = {pos_z_i, pos_y_i, pos_x_i};
  assign accept = start && !busy;
  assign store_en = accept && (count_q < CountWidth'(MaxVertices));
  assign busy = (state_q != StIdle);
  assign last_k = ({1'b0, k_q} + CountWidth'(1)) == count_q;

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem_q[count_q[AddrWidth-1:0]] <= vin;
    end
    rd_q <= mem_q[k_q];
  end

  always_comb begin
    big_c = '0;
    for (int a = 0; a < 3; a++) begin
      if ($signed(max_q[a]) > $signed(min_q[a])) begin
        ext_c[a] = max_q[a] - min_q[a];
      end else begin
        ext_c[a] = '0;
      end
      if (ext_c[a] > big_c) big_c = ext_c[a];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept && last_vertex_i) state_d = StExt;
      StExt:  state_d = StRead;
      StRead: state_d = StLoad;
      StLoad: state_d = StDiv;
      StDiv:  if (step_q == StepWidth'(QuotWidth - 1)) state_d = StOut;
      StOut:  state_d = last_k ? StIdle : StRead;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      drop_q  <= 1'b0;
      k_q     <= '0;
      step_q  <= '0;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= {1'b0, {(CoordWidth-1){1'b1}}};
        max_q[a] <= {1'b1, {(CoordWidth-1){1'b0}}};
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (store_en) begin
          count_q <= count_q + CountWidth'(1);
          for (int a = 0; a < 3; a++) begin
            if ($signed(vin[a]) < $signed(min_q[a])) min_q[a] <= vin[a];
            if ($signed(vin[a]) > $signed(max_q[a])) max_q[a] <= vin[a];
          end
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (state_q == StLoad) step_q <= '0;
      if (state_q == StDiv) step_q <= step_q + StepWidth'(1);
      if (state_q == StOut) begin
        if (last_k) begin
          k_q     <= '0;
          count_q <= '0;
          drop_q  <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            min_q[a] <= {1'b0, {(CoordWidth-1){1'b1}}};
            max_q[a] <= {1'b1, {(CoordWidth-1){1'b0}}};
          end
        end else begin
          k_q <= k_q + AddrWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [RemWidth:0] n_v;
    logic [MagWidth-1:0] mag_v;
    logic [RemWidth-1:0] sh_v;
    if (state_q == StExt) begin
      ext_q   <= ext_c;
      big_q   <= big_c;
      degen_q <= (big_c == '0);
    end
    if (state_q == StLoad) begin
      low_q <= big_q[QuotWidth-1:0];
      for (int a = 0; a < 3; a++) begin
        n_v = (RemWidth+1)'(($signed({{3{rd_q[a*CoordWidth+CoordWidth-1]}},
              rd_q[a*CoordWidth +: CoordWidth]}) - $signed({{3{min_q[a][CoordWidth-1]}},
              min_q[a]})) <<< 1) - $signed({3'b000, ext_q[a]});
        neg_q[a] <= n_v[RemWidth];
        mag_v = n_v[RemWidth] ? MagWidth'(-n_v) : MagWidth'(n_v);
        rem_q[a] <= RemWidth'(mag_v) + RemWidth'(big_q[ExtWidth-1]);
        quo_q[a] <= '0;
      end
    end
    if (state_q == StDiv) begin
      low_q <= {low_q[QuotWidth-2:0], 1'b0};
      for (int a = 0; a < 3; a++) begin
        sh_v = {rem_q[a][RemWidth-2:0], low_q[QuotWidth-1]};
        if ({1'b0, sh_v} >= {1'b0, big_q, 1'b0}) begin
          rem_q[a] <= sh_v - {1'b0, big_q, 1'b0};
          quo_q[a] <= {quo_q[a][QuotWidth-2:0], 1'b1};
        end else begin
          rem_q[a] <= sh_v;
          quo_q[a] <= {quo_q[a][QuotWidth-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [QuotWidth-1:0] q_v;
      q_v = (quo_q[a] > QOne) ? QOne : quo_q[a];
      if (degen_q) begin
        norm_c[a] = '0;
      end else if (neg_q[a]) begin
        norm_c[a] = NormWidth'(-{1'b0, q_v});
      end else begin
        norm_c[a] = NormWidth'({1'b0, q_v});
      end
    end
  end

  assign result_valid_o = (state_q == StOut);
  assign norm_x_o       = norm_c[0];
  assign norm_y_o       = norm_c[1];
  assign norm_z_o       = norm_c[2];
  assign vertex_index_o = k_q;
  assign last_result_o  = last_k;
  assign degenerate_o   = degen_q;
  assign overflow_o     = drop_q;

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountWidth'(MaxVertices)) else $error("vertex count beyond capacity");
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside emit pass");
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |=> (!busy && count_q == '0))
    else $error("mesh state not cleared after last result");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ({1'b0, vertex_index_o} < count_q))
    else $error("read of unwritten entry");
`endif
endmodule
`default_nettype wire

[tb/sv/tb_mesh_bounding_box_normalize.sv]
// Testbench for the mesh bounding box normalizer: directed and random meshes, checked per result.
`timescale 1ns / 1ps
module tb_mesh_bounding_box_normalize;
  import mbbn_pkg::*;

  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [CoordWidth-1:0] x, y, z;
    logic                  last;
    int                    gap_pct;
    bit                    drain;
  } vertex_t;

  typedef struct {
    logic [NormWidth-1:0] nx, ny, nz;
    logic [AddrWidth-1:0] idx;
    logic                 last, degen, ovf;
  } norm_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CoordWidth-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic last_vertex_i = 1'b0;
  logic result_valid_o;
  logic [NormWidth-1:0] norm_x_o, norm_y_o, norm_z_o;
  logic [AddrWidth-1:0] vertex_index_o;
  logic last_result_o, degenerate_o, overflow_o;

  vertex_t pending_vertices[$];
  norm_t   expected_norms[$];
  vertex_t cur;
  int      errors = 0;
  int      cycles = 0;
  int      cur_gap = 0;

  longint  mesh_coords[MaxVertices][3];
  longint  box_min[3], box_max[3];
  int      mesh_count = 0;
  bit      mesh_dropped = 1'b0;

  mesh_bounding_box_normalize DUT (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void clear_box();
    for (int a = 0; a < 3; a++) begin
      box_min[a] = 32767;
      box_max[a] = -32768;
    end
    mesh_count = 0;
    mesh_dropped = 1'b0;
  endfunction

  function automatic logic [NormWidth-1:0] scale_axis(longint v, longint mn, longint ext,
                                                      longint big);
    longint n, mag, q;
    n = 2 * (v - mn) - ext;
    mag = (n < 0) ? -n : n;
    q = (mag * 2 * 16384 + big) / (2 * big);
    if (q > 16384) q = 16384;
    return (n < 0) ? NormWidth'(-q) : NormWidth'(q);
  endfunction

  function automatic void predict_mesh(vertex_t vin);
    longint v[3], ext[3], big;
    norm_t r;
    v[0] = longint'($signed(vin.x));
    v[1] = longint'($signed(vin.y));
    v[2] = longint'($signed(vin.z));
    if (mesh_count < MaxVertices) begin
      for (int a = 0; a < 3; a++) begin
        mesh_coords[mesh_count][a] = v[a];
        if (v[a] < box_min[a]) box_min[a] = v[a];
        if (v[a] > box_max[a]) box_max[a] = v[a];
      end
      mesh_count++;
    end else begin
      mesh_dropped = 1'b1;
    end
    if (!vin.last) return;
    big = 0;
    for (int a = 0; a < 3; a++) begin
      ext[a] = box_max[a] - box_min[a];
      if (ext[a] < 0) ext[a] = 0;
      if (ext[a] > big) big = ext[a];
    end
    for (int k = 0; k < mesh_count; k++) begin
      r.nx = (big == 0) ? '0 : scale_axis(mesh_coords[k][0], box_min[0], ext[0], big);
      r.ny = (big == 0) ? '0 : scale_axis(mesh_coords[k][1], box_min[1], ext[1], big);
      r.nz = (big == 0) ? '0 : scale_axis(mesh_coords[k][2], box_min[2], ext[2], big);
      r.idx = AddrWidth'(k);
      r.last = (k + 1 == mesh_count);
      r.degen = (big == 0);
      r.ovf = mesh_dropped;
      expected_norms.insert(expected_norms.size(), r);
    end
    clear_box();
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_mesh(cur);
      if (!start || !busy) begin
        if (pending_vertices.size() > 0 &&
            !(pending_vertices[0].drain && expected_norms.size() > 0) &&
            $urandom_range(99) >= pending_vertices[0].gap_pct) begin
          cur = pending_vertices.pop_front();
          pos_x_i <= cur.x;
          pos_y_i <= cur.y;
          pos_z_i <= cur.z;
          last_vertex_i <= cur.last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    norm_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_norms.size() == 0) begin
        $error("unexpected result, index %0d", vertex_index_o);
        errors++;
      end else begin
        e = expected_norms.pop_front();
        if (norm_x_o !== e.nx) begin
          $error("norm_x: expected %0d, got %0d", $signed(e.nx), $signed(norm_x_o)); errors++;
        end
        if (norm_y_o !== e.ny) begin
          $error("norm_y: expected %0d, got %0d", $signed(e.ny), $signed(norm_y_o)); errors++;
        end
        if (norm_z_o !== e.nz) begin
          $error("norm_z: expected %0d, got %0d", $signed(e.nz), $signed(norm_z_o)); errors++;
        end
        if (vertex_index_o !== e.idx) begin
          $error("vertex_index: expected %0d, got %0d", e.idx, vertex_index_o); errors++;
        end
        if (last_result_o !== e.last) begin
          $error("last_result: expected %0d, got %0d", e.last, last_result_o); errors++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate: expected %0d, got %0d", e.degen, degenerate_o); errors++;
        end
        if (overflow_o !== e.ovf) begin
          $error("overflow: expected %0d, got %0d", e.ovf, overflow_o); errors++;
        end
      end
    end
  end

  function automatic void push_vertex(int x, int y, int z, bit last, bit drain = 1'b0);
    vertex_t v;
    v.x = CoordWidth'(x);
    v.y = CoordWidth'(y);
    v.z = CoordWidth'(z);
    v.last = last;
    v.gap_pct = cur_gap;
    v.drain = drain;
    pending_vertices.insert(pending_vertices.size(), v);
  endfunction

  function automatic int rand_coord(bit narrow, int base);
    if (narrow) return base + $urandom_range(40) - 20;
    return int'($signed(16'($urandom)));
  endfunction

  task automatic add_mesh(int n, bit drain);
    bit narrow;
    int bx, by, bz;
    narrow = $urandom_range(1);
    bx = $urandom_range(60000) - 30000;
    by = $urandom_range(60000) - 30000;
    bz = $urandom_range(60000) - 30000;
    for (int i = 0; i < n; i++)
      push_vertex(rand_coord(narrow, bx), rand_coord(narrow, by), rand_coord(narrow, bz),
                  i == n - 1, drain && i == 0);
  endtask

  initial begin
    int gaps[4];
    gaps = '{0, 61, 0, 35};
    clear_box();
    // directed: single vertex, full range, rounding tie, flat mesh, degenerate mesh, zero extent on one axis
    push_vertex(5, -7, 9, 1'b1);
    push_vertex(-32768, -32768, 32767, 1'b0);
    push_vertex(32767, 32767, -32768, 1'b1);
    push_vertex(-16384, 0, 0, 1'b0);
    push_vertex(16384, 1, 0, 1'b1);
    push_vertex(0, 0, 0, 1'b0);
    push_vertex(1, 3, 0, 1'b0);
    push_vertex(3, 1, 0, 1'b1);
    push_vertex(100, 100, 100, 1'b0);
    push_vertex(100, 100, 100, 1'b0);
    push_vertex(100, 100, 100, 1'b1);
    push_vertex(-1, 21845, 7, 1'b0);
    push_vertex(-1, -21846, 8, 1'b0);
    push_vertex(-1, 0, 9, 1'b1);
    for (int p = 0; p < 4; p++) begin
      cur_gap = gaps[p];
      for (int m = 0; m < 3; m++) add_mesh($urandom_range(1, 5), p == 1 && m == 0);
    end
    cur_gap = 35;
    add_mesh(MaxVertices + 2, 1'b0);
    add_mesh(3, 1'b0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_vertices.size() != 0 || start) @(posedge clk_i);
    while (expected_norms.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
